// File: hdl/tsvc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsvc_pkg
// Shared types and constants of the track section visibility cull unit.
// ---------------------------------------------------------------------------
package tsvc_pkg;

    localparam int SECTIONS_DEF    = 1024;
    localparam int WALK_LENGTH_DEF = 30;
    localparam int IDX_W           = 10;
    localparam int COORD_W         = 24;
    localparam int RAD_W           = 15;
    localparam int OBJ_W           = 15;
    localparam int MAG_W           = 25;
    localparam int SQ_W            = 52;
    localparam int ROOT_W          = 26;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_BOX,
        ST_ROOT,
        ST_DECIDE,
        ST_DONE
    } t_state;

    // request to the near-test unit
    typedef struct packed {
        logic                      start;
        logic signed [COORD_W-1:0] dx_a;
        logic signed [COORD_W-1:0] dx_b;
        logic signed [COORD_W-1:0] dy_a;
        logic signed [COORD_W-1:0] dy_b;
        logic signed [COORD_W-1:0] dz_a;
        logic signed [COORD_W-1:0] dz_b;
        logic [RAD_W:0]            box;
        logic [RAD_W-1:0]          rad;
        logic [RAD_W-1:0]          ext;
    } t_near_req;

    typedef struct packed {
        logic done;
        logic pass;
    } t_near_rsp;

endpackage

// File: hdl/tsvc_near.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsvc_near
// Box precheck and distance test of one object against one section centre.
// Squares the three axis offsets in turn, then a bit-pair-per-cycle integer square root.
// ---------------------------------------------------------------------------
module tsvc_near (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tsvc_pkg::t_near_req i_req,
    output tsvc_pkg::t_near_rsp o_rsp
);
    import tsvc_pkg::*;

    typedef enum logic [2:0] {
        N_IDLE, N_SQX, N_SQY, N_SQZ, N_ROOT
    } t_nstate;

    t_nstate           r_st, n_st;
    logic [MAG_W-1:0]  r_ax, r_ay, r_az;
    logic [SQ_W+1:0]   r_n;
    logic [SQ_W+1:0]   r_res;
    logic [4:0]        r_cnt;
    logic [RAD_W-1:0]  r_rad, r_ext;
    logic              r_done, r_fin;
    logic [2*MAG_W-1:0] w_sq;
    logic [MAG_W-1:0]  w_sel;
    logic [SQ_W+1:0]   w_bit, w_trial;
    logic [MAG_W:0]    w_dx, w_dy, w_dz;
    logic [MAG_W-1:0]  w_ax, w_ay, w_az;
    logic              w_box;
    logic [ROOT_W+1:0] w_diff;

    always_comb begin
        w_dx = {i_req.dx_a[COORD_W-1], i_req.dx_a, 1'b0} - {i_req.dx_b[COORD_W-1], i_req.dx_b, 1'b0};
        w_dy = {i_req.dy_a[COORD_W-1], i_req.dy_a, 1'b0} - {i_req.dy_b[COORD_W-1], i_req.dy_b, 1'b0};
        w_dz = {i_req.dz_a[COORD_W-1], i_req.dz_a, 1'b0} - {i_req.dz_b[COORD_W-1], i_req.dz_b, 1'b0};
        w_ax = w_dx[MAG_W] ? MAG_W'(-w_dx[MAG_W:1]) : w_dx[MAG_W:1];
        w_ay = w_dy[MAG_W] ? MAG_W'(-w_dy[MAG_W:1]) : w_dy[MAG_W:1];
        w_az = w_dz[MAG_W] ? MAG_W'(-w_dz[MAG_W:1]) : w_dz[MAG_W:1];
        w_box = (w_ax < MAG_W'(i_req.box)) && (w_ay < MAG_W'(i_req.box))
                && (w_az < MAG_W'(i_req.box));
    end

    always_comb begin
        unique case (r_st)
            N_SQX:   w_sel = r_ax;
            N_SQY:   w_sel = r_ay;
            default: w_sel = r_az;
        endcase
        w_sq    = w_sel * w_sel;
        w_bit   = (SQ_W+2)'(1) << {r_cnt, 1'b0};
        w_trial = r_res + w_bit;
        w_diff  = {1'b0, r_res[ROOT_W:0]} - (ROOT_W+2)'(r_ext);
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            N_IDLE:  if (i_req.start && w_box) n_st = N_SQX;
            N_SQX:   n_st = N_SQY;
            N_SQY:   n_st = N_SQZ;
            N_SQZ:   n_st = N_ROOT;
            N_ROOT:  if (r_cnt == 5'd0) n_st = N_IDLE;
            default: n_st = N_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= N_IDLE;
            r_done <= 1'b0;
            r_fin  <= 1'b0;
        end else begin
            r_st   <= n_st;
            // done is registered both for a box miss (from the start) and for a root (from its last step)
            r_done <= (r_st == N_IDLE) && i_req.start && !w_box;
            r_fin  <= (r_st == N_ROOT) && (r_cnt == 5'd0);
        end
        unique case (r_st)
            N_IDLE: begin
                r_ax  <= w_ax;
                r_ay  <= w_ay;
                r_az  <= w_az;
                r_rad <= i_req.rad;
                r_ext <= i_req.ext;
                r_n   <= '0;
            end
            N_SQX, N_SQY: r_n <= r_n + (SQ_W+2)'(w_sq);
            N_SQZ: begin
                r_n   <= r_n + (SQ_W+2)'(w_sq);
                r_res <= '0;
                r_cnt <= 5'd26;
            end
            N_ROOT: begin
                // one result bit per cycle, classic restoring root
                if (r_n >= w_trial) begin
                    r_n   <= r_n - w_trial;
                    r_res <= (r_res >> 1) + w_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_cnt <= r_cnt - 5'd1;
            end
            default: ;
        endcase
    end

    assign o_rsp.done = r_done || r_fin;
    assign o_rsp.pass = r_fin && (w_diff[ROOT_W+1] || (w_diff[ROOT_W:0] < (ROOT_W+1)'(r_rad)));

endmodule

// File: hdl/track_section_visibility_cull_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// track_section_visibility_cull_unit
// A load writes the tables and ends. A query tests a section by read, start,
// three squares, 27-step root and decide when the box check passes, or by read,
// start and decide when it fails; one global test plus up to 60 walked sections.
// Throughput: one transaction at a time; busy stays high until it finishes.
// Result strobe lasts one cycle and the receiver cannot stall it.
// Reset clears control only; section tables are undefined until loaded.
// ---------------------------------------------------------------------------
module track_section_visibility_cull_unit #(
    parameter int SECTIONS    = tsvc_pkg::SECTIONS_DEF,
    parameter int WALK_LENGTH = tsvc_pkg::WALK_LENGTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_req_type,
    input  logic [tsvc_pkg::IDX_W-1:0]           i_section_index,
    input  logic signed [tsvc_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [tsvc_pkg::COORD_W-1:0]  i_coord_y,
    input  logic signed [tsvc_pkg::COORD_W-1:0]  i_coord_z,
    input  logic [tsvc_pkg::IDX_W-1:0]           i_next_index,
    input  logic [tsvc_pkg::IDX_W-1:0]           i_prev_index,
    input  logic [tsvc_pkg::RAD_W-1:0]           i_global_radius,
    input  logic [tsvc_pkg::RAD_W-1:0]           i_local_radius,
    input  logic                                 i_jump_flag,
    input  logic [tsvc_pkg::RAD_W-1:0]           i_extent,
    input  logic [tsvc_pkg::OBJ_W-1:0]           i_object_index,
    output logic                                 o_valid,
    output logic [tsvc_pkg::IDX_W-1:0]           o_result_section,
    output logic [tsvc_pkg::OBJ_W-1:0]           o_result_object,
    output logic                                 o_in_global,
    output logic                                 o_visible
);
    import tsvc_pkg::*;

    localparam int AW = $clog2(SECTIONS);
    localparam int WW = $clog2(WALK_LENGTH + 1);

    logic signed [COORD_W-1:0] m_cx [SECTIONS];
    logic signed [COORD_W-1:0] m_cy [SECTIONS];
    logic signed [COORD_W-1:0] m_cz [SECTIONS];
    logic [2*IDX_W-1:0]        m_link [SECTIONS];
    logic [2*RAD_W:0]          m_rad [SECTIONS];

    logic signed [COORD_W-1:0] r_rd_cx, r_rd_cy, r_rd_cz;
    logic [2*IDX_W-1:0]        r_rd_link;
    logic [2*RAD_W:0]          r_rd_rad;

    t_state                    r_st, n_st;
    logic [AW-1:0]             r_addr, n_addr;
    logic [IDX_W-1:0]          r_sec;
    logic [OBJ_W-1:0]          r_obj;
    logic signed [COORD_W-1:0] r_px, r_py, r_pz;
    logic [RAD_W-1:0]          r_ext, r_lr;
    logic                      r_global_ph, r_back, r_inglob, r_vis;
    logic [WW-1:0]             r_step;
    logic                      r_valid;
    logic                      r_query;
    logic                      w_accept, w_load;
    t_near_req                 w_req;
    t_near_rsp                 w_rsp;
    logic [AW-1:0]             w_sec_a, w_link_a;

    assign w_accept = start && !busy;
    assign w_load   = w_accept && !i_req_type;
    assign busy     = (r_st != ST_IDLE);
    assign w_sec_a  = AW'(32'(i_section_index) % SECTIONS);
    assign w_link_a = r_back ? AW'(32'(r_rd_link[2*IDX_W-1:IDX_W]) % SECTIONS)
                             : AW'(32'(r_rd_link[IDX_W-1:0]) % SECTIONS);

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            m_cx[w_sec_a]   <= i_coord_x;
            m_cy[w_sec_a]   <= i_coord_y;
            m_cz[w_sec_a]   <= i_coord_z;
            m_link[w_sec_a] <= {i_prev_index, i_next_index};
            m_rad[w_sec_a]  <= {i_jump_flag, i_local_radius, i_global_radius};
        end
        r_rd_cx   <= m_cx[r_addr];
        r_rd_cy   <= m_cy[r_addr];
        r_rd_cz   <= m_cz[r_addr];
        r_rd_link <= m_link[r_addr];
        r_rd_rad  <= m_rad[r_addr];
    end

    tsvc_near u_near (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        w_req.start = (r_st == ST_BOX);
        w_req.dx_a  = r_px;
        w_req.dx_b  = r_rd_cx;
        w_req.dy_a  = r_py;
        w_req.dy_b  = r_rd_cy;
        w_req.dz_a  = r_pz;
        w_req.dz_b  = r_rd_cz;
        w_req.ext   = r_ext;
        if (r_global_ph) begin
            w_req.box = r_rd_rad[2*RAD_W] ? {r_rd_rad[RAD_W-1:0], 1'b0}
                                          : {1'b0, r_rd_rad[RAD_W-1:0]};
            w_req.rad = r_rd_rad[RAD_W-1:0];
        end else begin
            w_req.box = {1'b0, r_lr};
            w_req.rad = r_lr;
        end
    end

    always_comb begin
        n_st   = r_st;
        n_addr = r_addr;
        unique case (r_st)
            ST_IDLE: begin
                n_addr = w_sec_a;
                if (w_accept && i_req_type) n_st = ST_READ;
                else if (w_load) n_st = ST_DONE;
            end
            ST_READ:   n_st = ST_BOX;
            ST_BOX:    n_st = ST_ROOT;
            ST_ROOT:   if (w_rsp.done) n_st = ST_DECIDE;
            ST_DECIDE: begin
                // advance along the links or finish
                if (r_global_ph) begin
                    n_st = r_inglob ? ST_READ : ST_DONE;
                end else if (r_vis) begin
                    n_st = ST_DONE;
                end else if (r_step == WW'(WALK_LENGTH)) begin
                    if (r_back) n_st = ST_DONE;
                    else begin
                        n_addr = AW'(32'(r_sec) % SECTIONS);
                        n_st   = ST_READ;
                    end
                end else begin
                    n_addr = w_link_a;
                    n_st   = ST_READ;
                end
            end
            ST_DONE:   n_st = ST_IDLE;
            default:   n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_valid <= (r_st == ST_DONE) && r_global_ph == 1'b0 ? r_query : 1'b0;
        end
        r_addr <= n_addr;
        if (r_st == ST_IDLE && w_accept) begin
            r_sec       <= i_section_index;
            r_obj       <= i_object_index;
            r_px        <= i_coord_x;
            r_py        <= i_coord_y;
            r_pz        <= i_coord_z;
            r_ext       <= i_extent;
            r_global_ph <= 1'b1;
            r_back      <= 1'b0;
            r_inglob    <= 1'b0;
            r_vis       <= 1'b0;
            r_step      <= '0;
            r_query     <= i_req_type;
        end
        if (r_st == ST_ROOT && w_rsp.done) begin
            if (r_global_ph) begin
                r_inglob <= w_rsp.pass;
                r_lr     <= r_rd_rad[2*RAD_W-1:RAD_W];
            end else begin
                r_vis  <= w_rsp.pass;
                r_step <= r_step + WW'(1);
            end
        end
        if (r_st == ST_DECIDE) begin
            if (r_global_ph) begin
                r_global_ph <= 1'b0;
            end else if (!r_vis && r_step == WW'(WALK_LENGTH) && !r_back) begin
                r_back <= 1'b1;
                r_step <= '0;
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_result_section = r_sec;
    assign o_result_object  = r_obj;
    assign o_in_global      = r_inglob;
    assign o_visible        = r_vis;

    a_vis_implies_global: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_in_global || !o_visible)) else $error("visible without global");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_ROOT) |-> busy) else $error("idle during root");
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_IDLE) |-> (r_step <= WW'(WALK_LENGTH))) else $error("walk overran");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("strobe held");

endmodule

// File: tb/sv/tb_track_section_visibility_cull_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_track_section_visibility_cull_unit
// Self-checking bench for the track section cull unit. The whole section
// table is filled first, so every query and walk reads loaded entries. Then
// directed and random load/query traffic runs under several sender idling
// phases. A local model predicts each query outcome, and every strobed
// result is compared with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_track_section_visibility_cull_unit;
    import tsvc_pkg::*;

    localparam int NSEC      = SECTIONS_DEF;
    localparam int WALK      = WALK_LENGTH_DEF;
    localparam int CYCLE_CAP = 20_000_000;
    localparam int DRAIN     = 3000;
    localparam bit REQ_LOAD  = 1'b0;
    localparam bit REQ_QUERY = 1'b1;

    typedef struct {
        bit                      req_type;
        bit [IDX_W-1:0]          section;
        bit signed [COORD_W-1:0] x, y, z;
        bit [IDX_W-1:0]          next_idx, prev_idx;
        bit [RAD_W-1:0]          g_rad, l_rad;
        bit                      jump;
        bit [RAD_W-1:0]          extent;
        bit [OBJ_W-1:0]          object;
    } t_cull_req;

    typedef struct {
        bit [IDX_W-1:0] section;
        bit [OBJ_W-1:0] object;
        bit             in_global;
        bit             visible;
    } t_cull_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_req_type = 1'b0;
    logic [IDX_W-1:0] i_section_index = '0;
    logic signed [COORD_W-1:0] i_coord_x = '0, i_coord_y = '0, i_coord_z = '0;
    logic [IDX_W-1:0] i_next_index = '0, i_prev_index = '0;
    logic [RAD_W-1:0] i_global_radius = '0, i_local_radius = '0;
    logic i_jump_flag = 1'b0;
    logic [RAD_W-1:0] i_extent = '0;
    logic [OBJ_W-1:0] i_object_index = '0;
    logic o_valid;
    logic [IDX_W-1:0] o_result_section;
    logic [OBJ_W-1:0] o_result_object;
    logic o_in_global, o_visible;

    track_section_visibility_cull_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_section_index(i_section_index),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y), .i_coord_z(i_coord_z),
        .i_next_index(i_next_index), .i_prev_index(i_prev_index),
        .i_global_radius(i_global_radius), .i_local_radius(i_local_radius),
        .i_jump_flag(i_jump_flag), .i_extent(i_extent),
        .i_object_index(i_object_index), .o_valid(o_valid),
        .o_result_section(o_result_section), .o_result_object(o_result_object),
        .o_in_global(o_in_global), .o_visible(o_visible)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // section table copy
    int          centre_x[NSEC], centre_y[NSEC], centre_z[NSEC];
    int unsigned next_of[NSEC], prev_of[NSEC], grad_of[NSEC], lrad_of[NSEC];
    bit          jump_of[NSEC];

    t_cull_verdict pending_verdicts[$];
    int errors = 0;
    int cycles = 0;
    int idle_pct = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report(input string what);
        errors++;
        $display("mismatch @%0t: %s", $realtime, what);
    endtask

    function automatic longint unsigned isqrt(input longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint unsigned mag(input longint d);
        return (d < 0) ? longint'(-d) : d;
    endfunction

    function automatic bit near_hit(input int s, input int px, input int py,
                                    input int pz, input longint unsigned box,
                                    input longint unsigned rad,
                                    input longint unsigned ext);
        longint unsigned ax, ay, az, span;
        ax = mag(longint'(px) - centre_x[s]);
        ay = mag(longint'(py) - centre_y[s]);
        az = mag(longint'(pz) - centre_z[s]);
        if (!(ax < box && ay < box && az < box)) return 1'b0;
        span = isqrt(ax * ax + ay * ay + az * az);
        if (span < ext) return 1'b1;
        return (span - ext) < rad;
    endfunction

    // update the table on a load, or work out the verdict of a query
    function automatic bit cull_predict(input t_cull_req r,
                                        output t_cull_verdict v);
        int s, w, j;
        longint unsigned gr, lr, ext;
        bit hit;
        s = r.section;
        if (r.req_type == REQ_LOAD) begin
            centre_x[s] = r.x;
            centre_y[s] = r.y;
            centre_z[s] = r.z;
            next_of[s] = r.next_idx;
            prev_of[s] = r.prev_idx;
            grad_of[s] = r.g_rad;
            lrad_of[s] = r.l_rad;
            jump_of[s] = r.jump;
            return 1'b0;
        end
        gr = grad_of[s];
        lr = lrad_of[s];
        ext = r.extent;
        hit = 1'b0;
        v.section = r.section;
        v.object = r.object;
        v.in_global = near_hit(s, r.x, r.y, r.z, jump_of[s] ? gr * 2 : gr, gr, ext);
        if (v.in_global) begin
            w = s;
            for (j = 0; !hit && j < WALK; j++) begin
                hit = near_hit(w, r.x, r.y, r.z, lr, lr, ext);
                w = next_of[w] % NSEC;
            end
            w = s;
            for (j = 0; !hit && j < WALK; j++) begin
                hit = near_hit(w, r.x, r.y, r.z, lr, lr, ext);
                w = prev_of[w] % NSEC;
            end
        end
        v.visible = hit;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_cull_verdict want;
        if (i_rst_n && o_valid) begin
            if (pending_verdicts.size() == 0) begin
                report("result with no query pending");
            end else begin
                want = pending_verdicts.pop_front();
                if (o_result_section !== want.section)
                    report($sformatf("section %0d, want %0d", o_result_section,
                                     want.section));
                if (o_result_object !== want.object)
                    report($sformatf("object %0d, want %0d", o_result_object,
                                     want.object));
                if (o_in_global !== want.in_global)
                    report($sformatf("in_global %0b, want %0b (sec %0d obj %0d)",
                                     o_in_global, want.in_global, want.section,
                                     want.object));
                if (o_visible !== want.visible)
                    report($sformatf("visible %0b, want %0b (sec %0d obj %0d)",
                                     o_visible, want.visible, want.section,
                                     want.object));
            end
        end
    end

    // start stays high from one transaction into the next unless an idle gap falls
    task automatic send_request(input t_cull_req r);
        t_cull_verdict v;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        i_req_type <= r.req_type;
        i_section_index <= r.section;
        i_coord_x <= r.x;
        i_coord_y <= r.y;
        i_coord_z <= r.z;
        i_next_index <= r.next_idx;
        i_prev_index <= r.prev_idx;
        i_global_radius <= r.g_rad;
        i_local_radius <= r.l_rad;
        i_jump_flag <= r.jump;
        i_extent <= r.extent;
        i_object_index <= r.object;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (cull_predict(r, v)) pending_verdicts.push_back(v);
    endtask

    function automatic t_cull_req rand_req();
        t_cull_req r;
        r.req_type = $urandom_range(1);
        r.section = $urandom;
        r.x = $urandom;
        r.y = $urandom;
        r.z = $urandom;
        r.next_idx = $urandom;
        r.prev_idx = $urandom;
        r.g_rad = $urandom;
        r.l_rad = $urandom;
        r.jump = $urandom_range(1);
        r.extent = $urandom;
        r.object = $urandom;
        return r;
    endfunction

    // section mostly laid out along a straight track whose links wrap round into a ring
    function automatic t_cull_req track_load(input int s);
        t_cull_req r;
        r = rand_req();
        r.req_type = REQ_LOAD;
        r.section = s;
        if ($urandom_range(99) < 85) begin
            r.x = s * 2000 - 1_024_000 + $urandom_range(400) - 200;
            r.y = $urandom_range(1000) - 500;
            r.z = $urandom_range(1000) - 500;
            r.next_idx = (s + 1) % NSEC;
            r.prev_idx = (s + NSEC - 1) % NSEC;
            r.g_rad = $urandom_range(32767, 1000);
            r.l_rad = ($urandom_range(9) == 0) ? 0 : $urandom_range(6000);
        end
        return r;
    endfunction

    function automatic t_cull_req near_query();
        t_cull_req r;
        int s;
        r = rand_req();
        r.req_type = REQ_QUERY;
        s = r.section;
        if ($urandom_range(99) < 80) begin
            r.x = centre_x[s] + $urandom_range(8000) - 4000;
            r.y = centre_y[s] + $urandom_range(6000) - 3000;
            r.z = centre_z[s] + $urandom_range(6000) - 3000;
            r.extent = ($urandom_range(4) == 0) ? $urandom : $urandom_range(1500);
        end
        return r;
    endfunction

    // drop start so the last transaction is not taken twice
    task automatic wait_drain();
        start <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_fill_table();
        for (int s = 0; s < NSEC; s++) send_request(track_load(s));
    endtask

    task automatic test_directed();
        t_cull_req r;
        // jump section at the top corner of the space
        r = track_load(NSEC - 1);
        r.x = 24'sh7FFFFF; r.y = 24'sh7FFFFF; r.z = 24'sh7FFFFF;
        r.g_rad = '1; r.l_rad = '1; r.jump = 1'b1;
        r.next_idx = '1; r.prev_idx = '1;
        send_request(r);
        // zero radius section at the bottom corner
        r = track_load(0);
        r.x = -24'sd8388608; r.y = -24'sd8388608; r.z = -24'sd8388608;
        r.g_rad = '0; r.l_rad = '0; r.jump = 1'b0;
        r.next_idx = '0; r.prev_idx = '0;
        send_request(r);
        r = near_query();
        r.section = NSEC - 1; r.object = '1; r.extent = '0;
        r.x = 24'sh7FFFFF; r.y = 24'sh7FFFFF; r.z = 24'sh7FFFFF;
        send_request(r);
        // beyond the plain box, inside the doubled one
        r.x = 24'sh7FFFFF - 40000; r.extent = '1;
        send_request(r);
        r.x = 24'sh7FFFFF - 70000; r.extent = '0;
        send_request(r);
        // opposite corner of the space, far out of range
        r.x = -24'sd8388608; r.y = -24'sd8388608; r.z = -24'sd8388608;
        send_request(r);
        r.section = 0; r.object = '0;
        send_request(r);
        r.extent = '1;
        send_request(r);
        // extent larger than the distance on a normal section
        r = near_query();
        r.section = 500; r.x = centre_x[500] + 3000; r.y = centre_y[500];
        r.z = centre_z[500]; r.extent = '1;
        send_request(r);
        r.extent = '0;
        send_request(r);
        for (int k = 0; k < 8; k++) send_request(near_query());
        wait_drain();
    endtask

    task automatic test_random(input int pct, input int count);
        idle_pct = pct;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 25) send_request(track_load($urandom_range(NSEC - 1)));
            else send_request(near_query());
        end
        wait_drain();
        idle_pct = 0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_table();
        test_directed();
        test_random(0, 250);
        test_random(83, 250);
        test_random(0, 150);
        test_random(11, 250);
        start <= 1'b0;
        wait_drain();
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0 && pending_verdicts.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
